### hdl/sme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;
	localparam int STACK_DEPTH_DEF = 64;
	localparam logic [16:0] PC_MAX = 17'd65536;

	localparam logic [3:0] OP_PRINT = 4'd0;
	localparam logic [3:0] OP_PUSH  = 4'd1;
	localparam logic [3:0] OP_EXIT  = 4'd2;
	localparam logic [3:0] OP_POP   = 4'd3;
	localparam logic [3:0] OP_ADD   = 4'd4;
	localparam logic [3:0] OP_DIV   = 4'd5;
	localparam logic [3:0] OP_EQ    = 4'd6;
	localparam logic [3:0] OP_NEQ   = 4'd7;
	localparam logic [3:0] OP_DUP   = 4'd8;
	localparam logic [3:0] OP_JMP   = 4'd9;
	localparam logic [3:0] OP_JMPZ  = 4'd10;
	localparam logic [3:0] OP_WRITE = 4'd11;
	localparam logic [3:0] OP_WCHAR = 4'd12;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_EXIT  = 3'd1;
	localparam logic [2:0] ST_UNDER = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_ADDR  = 3'd4;
	localparam logic [2:0] ST_OPC   = 3'd5;
	localparam logic [2:0] ST_OVER  = 3'd6;

	localparam logic [1:0] EK_NONE  = 2'd0;
	localparam logic [1:0] EK_PRINT = 2'd1;
	localparam logic [1:0] EK_NUM   = 2'd2;
	localparam logic [1:0] EK_CHAR  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture instruction
		logic div_start;
		logic commit;   // apply result to stack and pc
	} sme_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic need_div; // instruction runs the divider
	} sme_sts_t;
endpackage
`default_nettype wire

### hdl/sme_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] dividend,
	input  wire  [63:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	// one restoring bit per cycle on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[63] ? (64'd0 - dividend) : dividend;
			den_q <= divisor[63] ? (64'd0 - divisor) : divisor;
			neg_q <= dividend[63] ^ divisor[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (64'd0 - quo_q) : quo_q;
endmodule
`default_nettype wire

### hdl/sme_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_axis_tvalid,
	output logic               s_axis_tready,
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output sme_pkg::sme_cmd_t  cmd,
	input  sme_pkg::sme_sts_t  sts
);
	import sme_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0] state_q;
	logic       ovalid_q;

	// take a request when idle and the result slot is free or draining
	assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);
	assign m_axis_tvalid = ovalid_q;

	always_comb begin
		cmd.load      = s_axis_tvalid && s_axis_tready;
		cmd.div_start = (state_q == S_EXEC) && sts.need_div;
		cmd.commit    = ((state_q == S_EXEC) && !sts.need_div) ||
			((state_q == S_DIV) && sts.div_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (m_axis_tready) ovalid_q <= 1'b0;
			if (cmd.commit) ovalid_q <= 1'b1;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_EXEC;
				S_EXEC: state_q <= sts.need_div ? S_DIV : S_IDLE;
				S_DIV:  if (sts.div_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit) else $error("double commit");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.load) else $error("load while busy");
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC)) else $error("load lost");
endmodule
`default_nettype wire

### hdl/sme_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_dp #(
	parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  sme_pkg::sme_cmd_t  cmd,
	output sme_pkg::sme_sts_t  sts,
	input  wire  [3:0]         opcode,
	input  wire  [63:0]        argument,
	input  wire                cfg_valid,
	input  wire  [16:0]        cfg_data,
	output logic [2:0]         status,
	output logic [16:0]        next_pc,
	output logic [63:0]        top_value,
	output logic [1:0]         emit_kind,
	output logic [63:0]        emit_value
);
	import sme_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	logic [63:0]   mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [16:0]   pc_q, codelen_q;
	logic [2:0]    stat_q;
	logic [3:0]    op_q;
	logic [63:0]   arg_q, a_q, b_q, top_q;
	logic [63:0]   rd_a, rd_b;
	logic [AW-1:0] ia, ib;
	logic          div_done;
	logic [63:0]   quo;

	// read addresses: top and second from the current count
	assign ia = AW'(cnt_q - CW'(1));
	assign ib = AW'(cnt_q - CW'(2));

	always_ff @(posedge clk) begin
		rd_a <= mem[ia];
		rd_b <= mem[ib];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			arg_q <= argument;
		end
	end
	assign a_q = rd_a;
	assign b_q = rd_b;

	sme_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(b_q), .divisor(a_q), .quotient(quo), .done(div_done)
	);

	// hold divider operands: reads stay stable since count does not move
	// decode checks
	logic        need1, need2, tgt_ok;
	logic [2:0]  err;
	logic [CW-1:0] need;
	logic [63:0] top_now;
	always_comb begin
		need1 = 1'b0;
		need2 = 1'b0;
		case (op_q)
			OP_PRINT, OP_EXIT, OP_POP, OP_DUP, OP_JMPZ, OP_WRITE, OP_WCHAR:
				need1 = 1'b1;
			OP_ADD, OP_DIV, OP_EQ, OP_NEQ: need2 = 1'b1;
			default: ;
		endcase
		need = need2 ? CW'(2) : (need1 ? CW'(1) : CW'(0));
		top_now = (cnt_q == '0) ? 64'd0 : a_q;
		tgt_ok = !arg_q[63] && (arg_q < {47'd0, codelen_q});
		if (op_q > OP_WCHAR) err = ST_OPC;
		else if (cnt_q < need) err = ST_UNDER;
		else if (op_q == OP_DIV && top_now == 64'd0) err = ST_DIVZ;
		else if ((op_q == OP_JMP || op_q == OP_JMPZ) && !tgt_ok) err = ST_ADDR;
		else if ((op_q == OP_PUSH || op_q == OP_DUP) && cnt_q >= DEPTH_C) err = ST_OVER;
		else err = ST_RUN;
	end

	assign sts.need_div = (stat_q == ST_RUN) && (err == ST_RUN) && (op_q == OP_DIV);
	assign sts.div_done = div_done;

	logic [16:0] npc;
	assign npc = (pc_q >= PC_MAX) ? PC_MAX : pc_q + 17'd1;

	// commit: update stack count, pc and status; load code length on cfg_valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pc_q      <= '0;
			stat_q    <= ST_RUN;
			codelen_q <= 17'd1;
		end else begin
			if (cfg_valid) codelen_q <= (cfg_data > PC_MAX) ? PC_MAX : cfg_data;
			if (cmd.commit && stat_q == ST_RUN) begin
				if (err != ST_RUN) stat_q <= err;
				else begin
					pc_q <= npc;
					case (op_q)
						OP_PUSH, OP_DUP: cnt_q <= cnt_q + CW'(1);
						OP_EXIT: stat_q <= ST_EXIT;
						OP_POP, OP_ADD, OP_DIV, OP_EQ, OP_NEQ: cnt_q <= cnt_q - CW'(1);
						OP_JMP: pc_q <= arg_q[16:0];
						OP_JMPZ: begin
							cnt_q <= cnt_q - CW'(1);
							if (a_q == 64'd0) pc_q <= arg_q[16:0];
						end
						default: ;
					endcase
				end
			end
		end
	end

	logic [63:0] wval;
	logic        wen;
	logic [AW-1:0] waddr;
	logic [CW-1:0] cnt_n;
	always_comb begin
		wen = cmd.commit && stat_q == ST_RUN && err == ST_RUN;
		wval = '0;
		waddr = ib;
		cnt_n = cnt_q;
		case (op_q)
			OP_PUSH: begin wval = arg_q; waddr = AW'(cnt_q); cnt_n = cnt_q + CW'(1); end
			OP_DUP:  begin wval = a_q; waddr = AW'(cnt_q); cnt_n = cnt_q + CW'(1); end
			OP_ADD:  begin wval = a_q + b_q; cnt_n = cnt_q - CW'(1); end
			OP_DIV:  begin wval = quo; cnt_n = cnt_q - CW'(1); end
			OP_EQ:   begin wval = {63'd0, a_q == b_q}; cnt_n = cnt_q - CW'(1); end
			OP_NEQ:  begin wval = {63'd0, a_q != b_q}; cnt_n = cnt_q - CW'(1); end
			default: begin
				wen = 1'b0;
				if (op_q == OP_POP || op_q == OP_JMPZ) cnt_n = cnt_q - CW'(1);
			end
		endcase
		if (!(stat_q == ST_RUN && err == ST_RUN)) cnt_n = cnt_q;
	end

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wval;
	end

	// top after commit: new value, the old second entry, unchanged, or zero when empty
	always_comb begin
		if (cnt_n == '0) top_q = 64'd0;
		else if (wen) top_q = wval;
		else if (cnt_n == cnt_q) top_q = a_q;
		else top_q = b_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			top_value  <= top_q;
			emit_kind  <= EK_NONE;
			emit_value <= '0;
			status     <= stat_q;
			next_pc    <= pc_q;
			if (stat_q == ST_RUN) begin
				if (err != ST_RUN) status <= err;
				else begin
					status  <= (op_q == OP_EXIT) ? ST_EXIT : ST_RUN;
					next_pc <= (op_q == OP_JMP || (op_q == OP_JMPZ && a_q == 64'd0))
						? arg_q[16:0] : npc;
					case (op_q)
						OP_PRINT: begin emit_kind <= EK_PRINT; emit_value <= a_q; end
						OP_WRITE: begin emit_kind <= EK_NUM; emit_value <= a_q; end
						OP_WCHAR: begin emit_kind <= EK_CHAR; emit_value <= {56'd0, a_q[7:0]}; end
						default: ;
					endcase
				end
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C) else $error("stack count out of range");
	a_stop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(stat_q != ST_RUN) |=> $stable(cnt_q) && $stable(pc_q)) else $error("stopped moved");
	a_div_err: assert property (@(posedge clk) disable iff (!arst_n)
		sts.need_div |-> a_q != 64'd0) else $error("div by zero started");
endmodule
`default_nettype wire

### hdl/stack_machine_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// Stack machine executor. Each request on the s_axis channel is one
// instruction the host fetched at the last returned next_pc; each one
// yields exactly one result on m_axis with status, next_pc, top of stack
// and an optional text event.
// A request is accepted in idle, runs in the execute state and its result is
// registered at commit; div instead runs a radix-2 divider in a divide state
// before commit. The block takes no new instruction until the last one has
// committed, and div holds it while the divider iterates. The stack memory
// read is registered ahead of the execute step.
// A new request is taken while the last result still waits, as long as the
// block is idle and the result slot drains in the same cycle; a stalled
// receiver holds the result and stops further accepts.
// The code_length register is written on cfg_valid/cfg_ready and bounds jump
// targets. Reset clears stack count, pc and status; stack contents are not
// cleared. Errors and exit freeze the machine until reset.
module stack_machine_execute #(
	parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [71:0] s_axis_tdata,  // opcode[3:0], argument[67:4], zero
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [151:0] m_axis_tdata, // status, next_pc, top_value, emit_kind, emit_value
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [16:0] cfg_data
);
	import sme_pkg::*;

	sme_cmd_t cmd;
	sme_sts_t sts;
	logic [2:0]  status;
	logic [16:0] next_pc;
	logic [63:0] top_value, emit_value;
	logic [1:0]  emit_kind;

	assign cfg_ready = 1'b1;

	sme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	sme_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.opcode(s_axis_tdata[3:0]), .argument(s_axis_tdata[67:4]),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.status(status), .next_pc(next_pc), .top_value(top_value),
		.emit_kind(emit_kind), .emit_value(emit_value)
	);

	assign m_axis_tdata = {2'd0, emit_value, emit_kind, top_value, next_pc, status};
endmodule
`default_nettype wire
